@@ rtl/gfp_pkg.sv @@
// gfp_pkg: shared constants, codes and the frame record type of the gps frame parser
`default_nettype none

package gfp_pkg;

	// header, trailer and marker bytes
	localparam logic [7:0] HDR_A    = 8'h04;
	localparam logic [7:0] HDR_B    = 8'h24;
	localparam logic [7:0] TRL_A    = 8'h0D;
	localparam logic [7:0] TRL_B    = 8'h0A;
	localparam logic [7:0] NEG_MARK = 8'h02;
	localparam logic [7:0] FIX_MARK = 8'h01;

	// byte positions within the frame
	localparam logic [5:0] POS_HUNT     = 6'd0;
	localparam logic [5:0] POS_HDR1     = 6'd1;
	localparam logic [5:0] POS_FIRST    = 6'd2;
	localparam logic [5:0] POS_TIME     = 6'd5;
	localparam logic [5:0] POS_LAT      = 6'd9;
	localparam logic [5:0] POS_NS       = 6'd10;
	localparam logic [5:0] POS_LON      = 6'd14;
	localparam logic [5:0] POS_EW       = 6'd15;
	localparam logic [5:0] POS_FIX      = 6'd16;
	localparam logic [5:0] POS_HEAD     = 6'd20;
	localparam logic [5:0] POS_KNOTS    = 6'd24;
	localparam logic [5:0] POS_KMH      = 6'd29;
	localparam logic [5:0] POS_LAST_XOR = 6'd30;
	localparam logic [5:0] POS_CKSUM    = 6'd31;
	localparam logic [5:0] POS_TRL_A    = 6'd32;
	localparam logic [5:0] POS_LAST     = 6'd33;

	// frame status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_CKSUM   = 2'd1,
		ST_BAD_TRAILER = 2'd2
	} status_t;

	// constant divisors of the time split
	localparam logic [16:0] DIV_MS = 17'd100000;
	localparam logic [6:0]  DIV_HM = 7'd100;

	// reciprocals, exact over the full 32-bit time range:
	// t / 100000 = ((t >> 5) * MUL_MS) >> 39, q / 100 = ((q >> 2) * MUL_HR) >> 19
	localparam logic [27:0] MUL_MS = 28'd175921861;
	localparam logic [14:0] MUL_HR = 15'd20972;

	// one finished frame as handed from front to back
	typedef struct packed {
		status_t     status;
		logic [31:0] time_val;
		logic [31:0] lat_mag;
		logic        lat_neg;
		logic [31:0] lon_mag;
		logic        lon_neg;
		logic [31:0] heading;
		logic [31:0] knots;
		logic [31:0] kmh;
		logic        fix;
	} frame_t;

endpackage

`default_nettype wire

@@ rtl/gfp_rx_if.sv @@
// gfp_rx_if: byte input channel of the gps frame parser
`default_nettype none

interface gfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/gfp_res_if.sv @@
// gfp_res_if: result channel of the gps frame parser
`default_nettype none

interface gfp_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         frame_status;
	logic [8:0]         hours;
	logic [6:0]         minutes;
	logic [16:0]        milliseconds;
	logic signed [32:0] latitude;
	logic signed [32:0] longitude;
	logic [31:0]        heading;
	logic [31:0]        speed_knots;
	logic [31:0]        speed_kmh;
	logic               fix_valid;

	modport source (output valid, output frame_status, output hours, output minutes,
		output milliseconds, output latitude, output longitude, output heading,
		output speed_knots, output speed_kmh, output fix_valid, input ready);
	modport sink (input valid, input frame_status, input hours, input minutes,
		input milliseconds, input latitude, input longitude, input heading,
		input speed_knots, input speed_kmh, input fix_valid, output ready);
endinterface

`default_nettype wire

@@ rtl/gfp_front.sv @@
// gfp_front: header hunt, byte position tracking, checksum and field capture
`default_nettype none

module gfp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	gfp_rx_if.sink             rx,
	input  wire logic          full,
	output logic               push,
	output gfp_pkg::frame_t    entry
);

	logic [5:0]  pos_q;
	logic [7:0]  xor_q;
	logic        south_q, west_q, fix_q, cks_q;
	logic [31:0] shift_q;
	logic [31:0] time_q, lat_q, lon_q, heading_q, knots_q, kmh_q;
	logic [31:0] shift_nx;
	logic [7:0]  b;
	logic        acc;

	// stall only when the last byte would find the queue full
	assign rx.ready = !((pos_q == gfp_pkg::POS_LAST) && full);
	assign acc      = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign shift_nx = {shift_q[23:0], b};
	assign push     = acc && (pos_q == gfp_pkg::POS_LAST);

	// position, checksum and flag tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= gfp_pkg::POS_HUNT;
			xor_q   <= '0;
			south_q <= 1'b0;
			west_q  <= 1'b0;
			fix_q   <= 1'b0;
			cks_q   <= 1'b0;
		end else if (acc) begin
			priority if (pos_q == gfp_pkg::POS_HUNT) begin
				pos_q <= (b == gfp_pkg::HDR_A) ? gfp_pkg::POS_HDR1 : gfp_pkg::POS_HUNT;
			end else if (pos_q == gfp_pkg::POS_HDR1) begin
				if (b == gfp_pkg::HDR_B) begin
					pos_q   <= gfp_pkg::POS_FIRST;
					xor_q   <= '0;
					south_q <= 1'b0;
					west_q  <= 1'b0;
					fix_q   <= 1'b0;
					cks_q   <= 1'b0;
				end else begin
					pos_q <= (b == gfp_pkg::HDR_A) ? gfp_pkg::POS_HDR1 : gfp_pkg::POS_HUNT;
				end
			end else begin
				if (pos_q <= gfp_pkg::POS_LAST_XOR)
					xor_q <= xor_q ^ b;
				if (pos_q == gfp_pkg::POS_NS && b == gfp_pkg::NEG_MARK)
					south_q <= 1'b1;
				if (pos_q == gfp_pkg::POS_EW && b == gfp_pkg::NEG_MARK)
					west_q <= 1'b1;
				if (pos_q == gfp_pkg::POS_FIX && b == gfp_pkg::FIX_MARK)
					fix_q <= 1'b1;
				if (pos_q == gfp_pkg::POS_CKSUM && b != xor_q)
					cks_q <= 1'b1;
				// after the first trailer byte the xor holds the trailer fault
				if (pos_q == gfp_pkg::POS_TRL_A)
					xor_q <= {7'd0, b != gfp_pkg::TRL_A};
				pos_q <= (pos_q == gfp_pkg::POS_LAST) ? gfp_pkg::POS_HUNT : 6'(pos_q + 6'd1);
			end
		end
	end

	// big-endian field assembly
	always_ff @(posedge clk) begin
		if (acc && pos_q >= gfp_pkg::POS_FIRST) begin
			shift_q <= shift_nx;
			if (pos_q == gfp_pkg::POS_TIME)  time_q    <= shift_nx;
			if (pos_q == gfp_pkg::POS_LAT)   lat_q     <= shift_nx;
			if (pos_q == gfp_pkg::POS_LON)   lon_q     <= shift_nx;
			if (pos_q == gfp_pkg::POS_HEAD)  heading_q <= shift_nx;
			if (pos_q == gfp_pkg::POS_KNOTS) knots_q   <= shift_nx;
			if (pos_q == gfp_pkg::POS_KMH)   kmh_q     <= shift_nx;
		end
	end

	// frame record, valid on the last byte
	always_comb begin
		entry.status = gfp_pkg::ST_OK;
		if (cks_q)
			entry.status = gfp_pkg::ST_BAD_CKSUM;
		else if (xor_q != 8'd0 || b != gfp_pkg::TRL_B)
			entry.status = gfp_pkg::ST_BAD_TRAILER;
		entry.time_val = time_q;
		entry.lat_mag  = lat_q;
		entry.lat_neg  = south_q;
		entry.lon_mag  = lon_q;
		entry.lon_neg  = west_q;
		entry.heading  = heading_q;
		entry.knots    = knots_q;
		entry.kmh      = kmh_q;
		entry.fix      = fix_q;
	end

	// checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= gfp_pkg::POS_LAST) else $error("byte position out of range");
	a_push_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> pos_q == gfp_pkg::POS_HUNT) else $error("no hunt after last byte");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> full) else $error("stall without full queue");

endmodule

`default_nettype wire

@@ rtl/gfp_queue.sv @@
// gfp_queue: two-entry frame record queue between front and back
`default_nettype none

module gfp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire gfp_pkg::frame_t wr_data,
	input  wire logic            pop,
	output logic                 full,
	output logic                 empty,
	output gfp_pkg::frame_t      head
);

	gfp_pkg::frame_t ent_q [2];
	logic            wr_q, rd_q;
	logic [1:0]      cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= 2'(cnt_q + 2'd1);
				2'b01:   cnt_q <= 2'(cnt_q - 2'd1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= wr_data;
	end

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ rtl/gfp_back.sv @@
// gfp_back: time split by reciprocal multiplication, sign apply, result register
`default_nettype none

module gfp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            empty,
	input  wire gfp_pkg::frame_t head,
	output logic                 pop,
	gfp_res_if.source            res
);

	typedef enum logic [2:0] {B_IDLE, B_MUL, B_QUOT, B_SPLIT, B_DONE} bstate_t;

	bstate_t                    state_q;
	gfp_pkg::frame_t            ent_q;
	logic [54:0]                prod_q;
	logic [15:0]                quot_q;
	logic [31:0]                qprod_q;
	logic [27:0]                hprod_q;
	logic [16:0]                ms_part_q;
	logic [8:0]                 hr_part_q;
	logic                       out_valid_q;
	logic [1:0]                 status_q;
	logic [8:0]                 hours_q;
	logic [6:0]                 minutes_q;
	logic [16:0]                ms_q;
	logic signed [32:0]         lat_q, lon_q;
	logic [31:0]                heading_q, knots_q, kmh_q;
	logic                       fix_q;
	logic [15:0]                quot_nx;
	logic [15:0]                min_nx;
	logic                       load_out;

	assign pop      = (state_q == B_IDLE) && !empty;
	assign load_out = (state_q == B_DONE) && (!out_valid_q || res.ready);

	// time / 100000 from the reciprocal product, minutes from the hour split
	assign quot_nx = prod_q[54:39];
	assign min_nx  = quot_q - 16'(hr_part_q) * 16'(gfp_pkg::DIV_HM);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						ent_q   <= head;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					prod_q  <= 55'(ent_q.time_val[31:5]) * 55'(gfp_pkg::MUL_MS);
					state_q <= B_QUOT;
				end
				B_QUOT: begin
					// quotient times 100000 stays below 2^32
					quot_q  <= quot_nx;
					qprod_q <= 32'(quot_nx) * 32'(gfp_pkg::DIV_MS);
					hprod_q <= 28'(quot_nx[15:2]) * 28'(gfp_pkg::MUL_HR);
					state_q <= B_SPLIT;
				end
				B_SPLIT: begin
					ms_part_q <= 17'(ent_q.time_val - qprod_q);
					hr_part_q <= hprod_q[27:19];
					state_q   <= B_DONE;
				end
				B_DONE: begin
					if (load_out)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
				status_q    <= ent_q.status;
				hours_q     <= hr_part_q;
				minutes_q   <= min_nx[6:0];
				ms_q        <= ms_part_q;
				lat_q       <= ent_q.lat_neg ? -$signed({1'b0, ent_q.lat_mag})
					: $signed({1'b0, ent_q.lat_mag});
				lon_q       <= ent_q.lon_neg ? -$signed({1'b0, ent_q.lon_mag})
					: $signed({1'b0, ent_q.lon_mag});
				heading_q   <= ent_q.heading;
				knots_q     <= ent_q.knots;
				kmh_q       <= ent_q.kmh;
				fix_q       <= ent_q.fix;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.frame_status = status_q;
	assign res.hours        = hours_q;
	assign res.minutes      = minutes_q;
	assign res.milliseconds = ms_q;
	assign res.latitude     = lat_q;
	assign res.longitude    = lon_q;
	assign res.heading      = heading_q;
	assign res.speed_knots  = knots_q;
	assign res.speed_kmh    = kmh_q;
	assign res.fix_valid    = fix_q;

	// checks
	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == B_MUL) else $error("time split did not start after pop");
	a_rem_sign: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SPLIT |-> qprod_q <= ent_q.time_val) else $error("quotient too large");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |=> out_valid_q) else $error("result item dropped");
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ms_q < gfp_pkg::DIV_MS && minutes_q < gfp_pkg::DIV_HM))
		else $error("time split out of range");

endmodule

`default_nettype wire

@@ rtl/gps_frame_parser.sv @@
// gps_frame_parser: top level of the byte-serial 34-byte gps frame parser
// Channels: rx carries one byte per item (rx_byte); res carries one result
// item per complete frame (status, hours, minutes, milliseconds, signed
// latitude and longitude, heading, both speeds, fix flag).
// Throughput: one byte per cycle; rx.ready stays high except on the last
// byte of a frame while the two-entry frame queue is full.
// Path: after the last frame byte is accepted, the back end takes the record
// from the queue, then registers the reciprocal multiply of the time value,
// then the quotient, its product and the hour multiply, then the millisecond
// and hour split, and last the result register. The back end handles one frame
// at a time and is through with it long before the 34 bytes of the next frame
// are in, so the byte stream waits only when the result receiver stalls.
// Reset: arst_n clears the byte position (header hunt), the queue and the
// result valid flag; no clearing pass is needed.
// Receiver stall: the result register holds its item; the back end waits,
// the queue fills, and only then is the last byte of a later frame held off.
`default_nettype none

module gps_frame_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	gfp_rx_if.sink    rx,
	gfp_res_if.source res
);

	gfp_pkg::frame_t wr_data;
	gfp_pkg::frame_t head;
	logic            push, pop, full, empty;

	// byte parser
	gfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.full   (full),
		.push   (push),
		.entry  (wr_data)
	);

	// frame queue
	gfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_data),
		.pop     (pop),
		.full    (full),
		.empty   (empty),
		.head    (head)
	);

	// time split and result
	gfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule

`default_nettype wire

@@ sim/tb_gps_frame_parser.sv @@
// tb_gps_frame_parser: self-checking bench for the gps frame parser with a frame predictor
`timescale 1ns / 1ps

module tb_gps_frame_parser;

	localparam int WATCH_LIMIT  = 5000;
	localparam int PRESS_CYCLES = 400;
	localparam int TAIL_CYCLES  = 60;

	// kinds of damage done to a generated frame
	typedef enum int {
		FLT_NONE,
		FLT_CKSUM,
		FLT_TRL_A,
		FLT_TRL_B,
		FLT_BOTH,
		FLT_GARBLE
	} fault_t;

	// one decoded frame as seen on the result channel
	typedef struct packed {
		logic [1:0]         frame_status;
		logic [8:0]         hours;
		logic [6:0]         minutes;
		logic [16:0]        milliseconds;
		logic signed [32:0] latitude;
		logic signed [32:0] longitude;
		logic [31:0]        heading;
		logic [31:0]        speed_knots;
		logic [31:0]        speed_kmh;
		logic               fix_valid;
	} fix_rec_t;

	// frame decoder model and queue of decoded frames still to arrive
	class gps_frame_board;
		logic [5:0]  pos;
		logic [7:0]  xsum;
		logic [31:0] shreg;
		logic [31:0] t_val, lat_mag, lon_mag, head, knots, kmh;
		bit          south, west, fix, cks_bad;
		fix_rec_t    decoded_q[$];
		int          errors;

		function new();
			pos = gfp_pkg::POS_HUNT;
			xsum = '0;
			shreg = '0;
			t_val = '0;
			lat_mag = '0;
			lon_mag = '0;
			head = '0;
			knots = '0;
			kmh = '0;
			south = 0;
			west = 0;
			fix = 0;
			cks_bad = 0;
			errors = 0;
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction

		// advance the decoder by one accepted byte
		function void note_byte(logic [7:0] b);
			fix_rec_t          r;
			int unsigned       t;
			gfp_pkg::status_t  st;
			case (pos)
				gfp_pkg::POS_HUNT: begin
					pos = (b == gfp_pkg::HDR_A) ? gfp_pkg::POS_HDR1 : gfp_pkg::POS_HUNT;
				end
				gfp_pkg::POS_HDR1: begin
					if (b == gfp_pkg::HDR_B) begin
						pos = gfp_pkg::POS_FIRST;
						xsum = '0;
						shreg = '0;
						south = 0;
						west = 0;
						fix = 0;
						cks_bad = 0;
					end else begin
						pos = (b == gfp_pkg::HDR_A) ? gfp_pkg::POS_HDR1 : gfp_pkg::POS_HUNT;
					end
				end
				default: begin
					if (pos <= gfp_pkg::POS_LAST_XOR)
						xsum = xsum ^ b;
					shreg = {shreg[23:0], b};
					case (pos)
						gfp_pkg::POS_TIME:  t_val = shreg;
						gfp_pkg::POS_LAT:   lat_mag = shreg;
						gfp_pkg::POS_NS:    if (b == gfp_pkg::NEG_MARK) south = 1;
						gfp_pkg::POS_LON:   lon_mag = shreg;
						gfp_pkg::POS_EW:    if (b == gfp_pkg::NEG_MARK) west = 1;
						gfp_pkg::POS_FIX:   if (b == gfp_pkg::FIX_MARK) fix = 1;
						gfp_pkg::POS_HEAD:  head = shreg;
						gfp_pkg::POS_KNOTS: knots = shreg;
						gfp_pkg::POS_KMH:   kmh = shreg;
						gfp_pkg::POS_CKSUM: if (b != xsum) cks_bad = 1;
						// from here on xsum only flags a bad first trailer byte
						gfp_pkg::POS_TRL_A: xsum = (b != gfp_pkg::TRL_A) ? 8'd1 : 8'd0;
						default: ;
					endcase
					if (pos != gfp_pkg::POS_LAST) begin
						pos = pos + 6'd1;
					end else begin
						// last byte: build the decoded frame
						if (cks_bad)
							st = gfp_pkg::ST_BAD_CKSUM;
						else if (xsum != 8'd0 || b != gfp_pkg::TRL_B)
							st = gfp_pkg::ST_BAD_TRAILER;
						else
							st = gfp_pkg::ST_OK;
						t = t_val;
						r.frame_status = st;
						r.hours = 9'(t / 32'd10000000);
						r.minutes = 7'((t / 32'd100000) % 32'd100);
						r.milliseconds = 17'(t % 32'd100000);
						r.latitude = south ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
						r.longitude = west ? -$signed({1'b0, lon_mag}) : $signed({1'b0, lon_mag});
						r.heading = head;
						r.speed_knots = knots;
						r.speed_kmh = kmh;
						r.fix_valid = fix;
						decoded_q.push_back(r);
						pos = gfp_pkg::POS_HUNT;
					end
				end
			endcase
		endfunction

		function void cmp_field(string nm, logic signed [63:0] e, logic signed [63:0] a);
			if (e !== a) begin
				$error("%s: expected %0d, got %0d", nm, e, a);
				errors++;
			end
		endfunction

		// compare one result item with the oldest decoded frame
		function void check_result(fix_rec_t got);
			fix_rec_t e;
			if (decoded_q.size() == 0) begin
				$error("result item with no frame pending");
				errors++;
				return;
			end
			e = decoded_q.pop_front();
			cmp_field("frame_status", e.frame_status, got.frame_status);
			cmp_field("hours", e.hours, got.hours);
			cmp_field("minutes", e.minutes, got.minutes);
			cmp_field("milliseconds", e.milliseconds, got.milliseconds);
			cmp_field("latitude", e.latitude, got.latitude);
			cmp_field("longitude", e.longitude, got.longitude);
			cmp_field("heading", e.heading, got.heading);
			cmp_field("speed_knots", e.speed_knots, got.speed_knots);
			cmp_field("speed_kmh", e.speed_kmh, got.speed_kmh);
			cmp_field("fix_valid", e.fix_valid, got.fix_valid);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gfp_rx_if  rx_ch();
	gfp_res_if res_ch();

	gps_frame_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	gps_frame_board sb = new();

	bit tx_quiet    = 0;
	bit press_req   = 0;
	int frame_bytes = 0;
	int frames_sent = 0;
	int idle_cycles = 0;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap(int busy_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < busy_pct)
			return 0;
		if (r < 97)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(0, 255));
			default: return $urandom();
		endcase
	endfunction

	// time values: mostly of the hhmmssSSS form, sometimes anything
	function automatic logic [31:0] pick_time();
		if ($urandom_range(0, 2) == 0)
			return pick32();
		return 32'($urandom_range(0, 235959999));
	endfunction

	function automatic logic [7:0] pick_mark(logic [7:0] mark);
		if ($urandom_range(0, 1) == 0)
			return mark;
		return 8'($urandom_range(0, 255));
	endfunction

	// any byte except v
	function automatic logic [7:0] not_byte(logic [7:0] v);
		logic [7:0] r8;
		r8 = 8'($urandom_range(0, 254));
		return (r8 >= v) ? r8 + 8'd1 : r8;
	endfunction

	function automatic fault_t pick_fault();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return FLT_NONE;
		if (r < 70) return FLT_CKSUM;
		if (r < 78) return FLT_TRL_A;
		if (r < 86) return FLT_TRL_B;
		if (r < 93) return FLT_BOTH;
		return FLT_GARBLE;
	endfunction

	// offer one byte, wait for the handshake and tell the decoder model
	task automatic send_byte(input logic [7:0] b);
		int n;
		n = tx_quiet ? 0 : pick_gap(80);
		if (n > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (rx_ch.ready !== 1'b1) @(posedge clk);
		sb.note_byte(b);
	endtask

	// assemble a 34-byte frame, damage it as asked, send it
	task automatic send_frame(input logic [31:0] tm, la, input logic [7:0] ns,
			input logic [31:0] lo, input logic [7:0] ew, fx, input logic [31:0] hd, kn,
			input logic [7:0] u1, input logic [31:0] km, input logic [7:0] u2,
			input fault_t flt);
		logic [7:0] fr [0:33];
		logic [7:0] x;
		fr[0] = gfp_pkg::HDR_A;
		fr[1] = gfp_pkg::HDR_B;
		{fr[2], fr[3], fr[4], fr[5]} = tm;
		{fr[6], fr[7], fr[8], fr[9]} = la;
		fr[10] = ns;
		{fr[11], fr[12], fr[13], fr[14]} = lo;
		fr[15] = ew;
		fr[16] = fx;
		{fr[17], fr[18], fr[19], fr[20]} = hd;
		{fr[21], fr[22], fr[23], fr[24]} = kn;
		fr[25] = u1;
		{fr[26], fr[27], fr[28], fr[29]} = km;
		fr[30] = u2;
		x = 8'h0;
		for (int i = 2; i <= 30; i++)
			x = x ^ fr[i];
		fr[31] = x;
		fr[32] = gfp_pkg::TRL_A;
		fr[33] = gfp_pkg::TRL_B;
		if (flt == FLT_CKSUM || flt == FLT_BOTH)
			fr[31] = x ^ 8'($urandom_range(1, 255));
		if (flt == FLT_TRL_A)
			fr[32] = not_byte(gfp_pkg::TRL_A);
		if (flt == FLT_TRL_B)
			fr[33] = not_byte(gfp_pkg::TRL_B);
		if (flt == FLT_BOTH) begin
			if ($urandom_range(0, 1) == 0)
				fr[32] = not_byte(gfp_pkg::TRL_A);
			else
				fr[33] = not_byte(gfp_pkg::TRL_B);
		end
		if (flt == FLT_GARBLE) begin
			for (int i = 2; i <= 33; i++)
				fr[i] = 8'($urandom_range(0, 255));
		end
		for (int i = 0; i < 34; i++)
			send_byte(fr[i]);
		frame_bytes += 34;
		frames_sent++;
	endtask

	task automatic send_random_frame(input fault_t flt);
		send_frame(pick_time(), pick32(), pick_mark(gfp_pkg::NEG_MARK), pick32(),
			pick_mark(gfp_pkg::NEG_MARK), pick_mark(gfp_pkg::FIX_MARK), pick32(), pick32(),
			8'($urandom_range(0, 255)), pick32(), 8'($urandom_range(0, 255)), flt);
	endtask

	// stop offering until every decoded frame has come out
	task automatic drain();
		rx_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCH_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// result side: random stalls, calm stretches, one long hold-off on request
	initial begin
		fix_rec_t got;
		int       stall_left;
		bit       calm;
		stall_left = 0;
		calm = 0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.frame_status = res_ch.frame_status;
				got.hours = res_ch.hours;
				got.minutes = res_ch.minutes;
				got.milliseconds = res_ch.milliseconds;
				got.latitude = res_ch.latitude;
				got.longitude = res_ch.longitude;
				got.heading = res_ch.heading;
				got.speed_knots = res_ch.speed_knots;
				got.speed_kmh = res_ch.speed_kmh;
				got.fix_valid = res_ch.fix_valid;
				sb.check_result(got);
			end
			if ($urandom_range(0, 299) == 0)
				calm = !calm;
			if (press_req) begin
				res_ch.ready <= 1'b0;
				repeat (PRESS_CYCLES) @(posedge clk);
				press_req = 0;
			end else begin
				if (stall_left == 0 && !calm)
					stall_left = pick_gap(85);
				res_ch.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
				@(posedge clk);
			end
		end
	end

	// byte side: reset, directed frames, random traffic, end of run
	initial begin
		int round;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header hunt: a lone 0x04 drops back, a repeated 0x04 holds
		send_byte(gfp_pkg::HDR_A);
		send_byte(8'h55);
		send_byte(gfp_pkg::HDR_A);
		// all-zero fields, plain marks, fix set
		send_frame(32'h0, 32'h0, 8'h00, 32'h0, 8'h00, gfp_pkg::FIX_MARK, 32'h0, 32'h0, 8'h4E,
			32'h0, 8'h4B, FLT_NONE);
		// full-scale fields, south and west, fix not set
		send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, gfp_pkg::NEG_MARK, 32'hFFFF_FFFF,
			gfp_pkg::NEG_MARK, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
			8'hFF, FLT_NONE);
		// header pattern inside a frame must not restart it
		send_frame(32'd123456789, 32'h0424_0424, gfp_pkg::HDR_A, 32'h2404_2404,
			gfp_pkg::HDR_B, gfp_pkg::HDR_A, 32'h0424_0000, 32'd5, gfp_pkg::HDR_A, 32'd9,
			gfp_pkg::HDR_B, FLT_NONE);
		// near-miss hemisphere and validity bytes
		send_frame(32'd235959999, 32'd40416775, 8'h03, 32'd3703790, 8'hFD, 8'h02,
			32'd359999999, 32'd12345, 8'h4E, 32'd22863, 8'h4B, FLT_NONE);
		// each fault on its own, then checksum and trailer together
		send_frame(32'd100000, 32'd1, gfp_pkg::NEG_MARK, 32'd2, 8'h01, gfp_pkg::FIX_MARK,
			32'd3, 32'd4, 8'h4E, 32'd5, 8'h4B, FLT_CKSUM);
		send_frame(32'd99999, 32'd7, 8'h01, 32'd8, gfp_pkg::NEG_MARK, 8'hFF, 32'd9, 32'd10,
			8'h4E, 32'd11, 8'h4B, FLT_TRL_A);
		send_frame(32'd10000000, pick32(), gfp_pkg::NEG_MARK, pick32(), gfp_pkg::NEG_MARK,
			gfp_pkg::FIX_MARK, pick32(), pick32(), 8'h4E, pick32(), 8'h4B, FLT_TRL_B);
		send_frame(32'd4294967295, pick32(), 8'h00, pick32(), 8'h00, gfp_pkg::FIX_MARK,
			pick32(), pick32(), 8'h4E, pick32(), 8'h4B, FLT_BOTH);
		drain();

		// random traffic: mostly good frames, some damaged, some noise and cut frames
		round = 0;
		while (frame_bytes < 1200 || frames_sent < 40) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 4))
					send_byte(($urandom_range(0, 3) == 0) ? gfp_pkg::HDR_A
						: 8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 24) == 0) begin
				// header then a frame cut short
				send_byte(gfp_pkg::HDR_A);
				send_byte(gfp_pkg::HDR_B);
				repeat ($urandom_range(0, 33))
					send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_random_frame(pick_fault());
			end
			// long hold-off on the result side while frames keep coming
			if (round == 10) begin
				tx_quiet = 1;
				press_req = 1;
				repeat (6) send_random_frame(FLT_NONE);
				tx_quiet = 0;
			end
			if (round == 25)
				drain();
			round++;
		end
		tx_quiet = 0;
		rx_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
